// ===== design/char_lcd_write_sequencer_unit_assert.svh =====
// Assertion macros used by the checker file of the LCD write sequencer.
// No dependencies; included by bare file name.
`ifndef CHAR_LCD_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/clws_pkg.sv =====
// Shared types, constants and functions of the LCD write sequencer.
// No dependencies; imported by every module of the block.
package clws_pkg;

    localparam int MaxDigits = 10;
    localparam int NumBits   = 32;
    localparam int BcdW      = MaxDigits * 4;
    localparam int DigitIdxW = $clog2(MaxDigits);
    localparam int IterW     = $clog2(NumBits);

    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    localparam logic [7:0] AsciiZero = 8'h30;
    localparam logic [7:0] RowBase [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_CHAR    = 2'd1,
        ACT_CURSOR  = 2'd2,
        ACT_NUMBER  = 2'd3
    } action_t;

    localparam logic [1:0] REG_FOUR_BIT_MODE  = 2'd0;
    localparam logic [1:0] REG_COMMAND_TICKS  = 2'd1;
    localparam logic [1:0] REG_CHAR_TICKS     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIZE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic size;
        logic emit;
    } clws_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic out_free;
        logic last_pulse;
    } clws_stat_t;

    // One double-dabble step: adjust each digit, then shift in one binary bit.
    // The top bit of the result is the bit shifted out of the BCD word.
    function automatic logic [BcdW:0] dd_step(input logic [BcdW-1:0] bcd,
                                              input logic bit_in);
        logic [BcdW-1:0] adj;
        adj = bcd;
        for (int i = 0; i < MaxDigits; i++) begin
            if (adj[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj, bit_in};
    endfunction

    // Position of the most significant nonzero digit, zero when all are zero.
    function automatic logic [DigitIdxW-1:0] top_digit(input logic [BcdW-1:0] bcd);
        logic [DigitIdxW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MaxDigits; i++) begin
            if (bcd[i*4 +: 4] != 4'd0)
            begin
                idx = DigitIdxW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/clws_ctrl.sv =====
// Controller state machine of the LCD write sequencer.
// Depends on clws_pkg; drives the datapath by command and reads its status.
module clws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             in_action,
    output logic                   in_ready,
    input  clws_pkg::clws_stat_t   stat,
    output clws_pkg::clws_cmd_t    cmd
);
    import clws_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action_t'(in_action) == ACT_NUMBER) ? ST_CONVERT : ST_EMIT;
                end
            end
            ST_CONVERT:
            begin
                if (stat.conv_last)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free && stat.last_pulse)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_SIZE:
            begin
                cmd.size = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/clws_datapath.sv =====
// Datapath of the LCD write sequencer: registers, decimal conversion, pulse output.
// Depends on clws_pkg; steered by clws_ctrl through command and status.
module clws_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic [1:0]                    in_action,
    input  logic [clws_pkg::InDataW-1:0]  in_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [clws_pkg::OutDataW-1:0] out_data,
    output logic                          out_rs,
    output logic                          out_last,
    input  clws_pkg::clws_cmd_t           cmd,
    output clws_pkg::clws_stat_t          stat
);
    import clws_pkg::*;

    logic                 mode_reg,       mode_next;
    logic [7:0]           cmd_ticks_reg,  cmd_ticks_next;
    logic [7:0]           char_ticks_reg, char_ticks_next;
    logic [7:0]           byte_reg,       byte_next;
    logic                 is_num_reg,     is_num_next;
    logic                 is_data_reg,    is_data_next;
    logic [NumBits-1:0]   bin_reg,        bin_next;
    logic [BcdW-1:0]      bcd_reg,        bcd_next;
    logic                 ovf_reg,        ovf_next;
    logic [IterW-1:0]     iter_reg,       iter_next;
    logic [DigitIdxW-1:0] digit_reg,      digit_next;
    logic                 phase_reg,      phase_next;
    logic                 out_valid_reg,  out_valid_next;
    logic                 out_rs_reg,     out_rs_next;
    logic [7:0]           out_lines_reg,  out_lines_next;
    logic [7:0]           out_hi_reg,     out_hi_next;
    logic [7:0]           out_lo_reg,     out_lo_next;
    logic                 out_last_reg,   out_last_next;

    action_t              act;
    logic [7:0]           in_byte;
    logic [NumBits-1:0]   in_number;
    logic [1:0]           in_row;
    logic [5:0]           in_col;
    logic [BcdW:0]        dd_res;
    logic [3:0]           digit_sel;
    logic [7:0]           cur_byte;
    logic                 last_c;

    assign act       = action_t'(in_action);
    assign in_byte   = in_data[7:0];
    assign in_number = in_data[39:8];
    assign in_row    = in_data[41:40];
    assign in_col    = in_data[47:42];

    assign dd_res    = dd_step(bcd_reg, bin_reg[NumBits-1]);
    assign digit_sel = bcd_reg[{digit_reg, 2'b00} +: 4];
    assign cur_byte  = is_num_reg ? (AsciiZero | {4'd0, digit_sel}) : byte_reg;
    assign last_c    = (digit_reg == '0) && (!mode_reg || phase_reg);

    assign stat.conv_last  = (iter_reg == IterW'(NumBits - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last_pulse = last_c;

    assign out_valid = out_valid_reg;
    assign out_data  = {out_lo_reg, out_hi_reg, out_lines_reg};
    assign out_rs    = out_rs_reg;
    assign out_last  = out_last_reg;

    always_comb begin
        mode_next       = mode_reg;
        cmd_ticks_next  = cmd_ticks_reg;
        char_ticks_next = char_ticks_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FOUR_BIT_MODE: mode_next       = cfg_data[0];
                REG_COMMAND_TICKS: cmd_ticks_next  = cfg_data;
                REG_CHAR_TICKS:    char_ticks_next = cfg_data;
                default:           mode_next       = mode_reg;
            endcase
        end
    end

    always_comb begin
        byte_next    = byte_reg;
        is_num_next  = is_num_reg;
        is_data_next = is_data_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        ovf_next     = ovf_reg;
        iter_next    = iter_reg;
        digit_next   = digit_reg;
        phase_next   = phase_reg;
        if (cmd.load)
        begin
            byte_next    = (act == ACT_CURSOR) ? RowBase[in_row] + {2'd0, in_col} : in_byte;
            is_num_next  = (act == ACT_NUMBER);
            is_data_next = (act == ACT_CHAR) || (act == ACT_NUMBER);
            bin_next     = in_number;
            bcd_next     = '0;
            ovf_next     = 1'b0;
            iter_next    = '0;
            digit_next   = '0;
            phase_next   = 1'b0;
        end
        if (cmd.conv_step)
        begin
            bcd_next  = dd_res[BcdW-1:0];
            ovf_next  = ovf_reg | dd_res[BcdW];
            bin_next  = {bin_reg[NumBits-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
        end
        if (cmd.size)
        begin
            digit_next = ovf_reg ? DigitIdxW'(MaxDigits - 1) : top_digit(bcd_reg);
        end
        if (cmd.emit)
        begin
            if (mode_reg && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                if (digit_reg != '0)
                begin
                    digit_next = digit_reg - 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_rs_next    = out_rs_reg;
        out_lines_next = out_lines_reg;
        out_hi_next    = out_hi_reg;
        out_lo_next    = out_lo_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_rs_next    = is_data_reg;
            out_hi_next    = is_data_reg ? char_ticks_reg : cmd_ticks_reg;
            out_lo_next    = (mode_reg && !is_data_reg) ? cmd_ticks_reg : 8'd0;
            out_last_next  = last_c;
            if (mode_reg)
            begin
                out_lines_next = {4'd0, phase_reg ? cur_byte[3:0] : cur_byte[7:4]};
            end
            else
            begin
                out_lines_next = cur_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            cmd_ticks_reg  <= 8'd5;
            char_ticks_reg <= 8'd10;
            out_valid_reg  <= 1'b0;
            iter_reg       <= '0;
            digit_reg      <= '0;
            phase_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            cmd_ticks_reg  <= cmd_ticks_next;
            char_ticks_reg <= char_ticks_next;
            out_valid_reg  <= out_valid_next;
            iter_reg       <= iter_next;
            digit_reg      <= digit_next;
            phase_reg      <= phase_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk) begin
        byte_reg      <= byte_next;
        is_num_reg    <= is_num_next;
        is_data_reg   <= is_data_next;
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        out_rs_reg    <= out_rs_next;
        out_lines_reg <= out_lines_next;
        out_hi_reg    <= out_hi_next;
        out_lo_reg    <= out_lo_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== design/char_lcd_write_sequencer_unit.sv =====
// Top level of the character LCD write sequencer.
// Depends on clws_pkg, clws_ctrl and clws_datapath.
//
//   Channel   Direction  Carries
//   s_axis    in         one request: kind in tuser, operands in tdata
//   m_axis    out        one enable pulse per transaction, tlast on the final one
//   cfg       in         register writes, index and data
//
// A command, character or cursor request is accepted and then sends one or two pulses.
// A number is accepted, run through binary-to-BCD shifting over all 32 bits, sized, and
// then sends one pulse per digit, or two per digit in four-bit mode, up to 20 pulses.
// The shift loop converts one bit per cycle. Only one request is in work at a time.
// A stall on m_axis holds the pending pulse in the output register.
// Reset is asynchronous and active low and restores the register defaults.
module char_lcd_write_sequencer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // byte_value, number_value, row_index, column_index
    input  logic [clws_pkg::InDataW-1:0]  s_axis_tdata,
    // action
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data_lines, enable_high_ticks, enable_low_ticks
    output logic [clws_pkg::OutDataW-1:0] m_axis_tdata,
    // register_select
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data
);
    import clws_pkg::*;

    clws_cmd_t  cmd;
    clws_stat_t stat;

    assign cfg_ready = 1'b1;

    clws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    clws_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_rs    (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== design/clws_checker.sv =====
// Port-level checks of the LCD write sequencer, bound to the top level.
// Depends on clws_pkg and char_lcd_write_sequencer_unit_assert.svh.
`include "char_lcd_write_sequencer_unit_assert.svh"

module clws_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [clws_pkg::OutDataW-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);
    import clws_pkg::*;

    logic                out_stall;
    logic                in_take;
    logic                data_pulse;
    logic                data_gap;
    logic [OutDataW+1:0] out_payload;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign in_take     = s_axis_tvalid && s_axis_tready;
    assign data_pulse  = m_axis_tvalid && m_axis_tuser;
    assign data_gap    = (m_axis_tdata[23:16] != 8'd0);
    assign out_payload = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `CLWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "Output lost in stall.")
    `CLWS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_payload), "Payload changed.")
    `CLWS_ASSERT_NOW(a_data_no_gap, clk, rst_n, data_pulse, !data_gap, "Data pulse has a gap.")
    `CLWS_ASSERT_NEXT(a_one_request, clk, rst_n, in_take, !s_axis_tready, "Second request taken.")

endmodule

bind char_lcd_write_sequencer_unit clws_checker u_clws_checker (.*);
